// ----- hdl/tpc_pkg.sv -----
// ---------------------------------------------------------------------------
// tpc_pkg
// Types, register codes and the patch-code function shared by the
// three-patch texture coder.
// ---------------------------------------------------------------------------
package tpc_pkg;

    // Window geometry and fixed ring radius.
    localparam int WIN         = 9;
    localparam int CTR         = 4;
    localparam int RING_RADIUS = 3;
    localparam int MAX_HEIGHT  = 4096;
    localparam int ROW_W       = 13;
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SKIP      = 2'd0;
    localparam logic [1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [1:0] CFG_WIDTH     = 2'd2;
    localparam logic [1:0] CFG_HEIGHT    = 2'd3;

    // Register reset values.
    localparam logic [2:0]  RST_SKIP      = 3'd1;
    localparam logic [7:0]  RST_THRESHOLD = 8'd50;
    localparam logic [9:0]  RST_WIDTH     = 10'd512;
    localparam logic [12:0] RST_HEIGHT    = 13'd512;

    // Patch centres inside the 9x9 window: the pixel first, then ring points 0..7.
    localparam int PATCH_ROW [WIN] = '{CTR, CTR - RING_RADIUS, CTR - RING_RADIUS,
                                       CTR - RING_RADIUS, CTR, CTR + RING_RADIUS,
                                       CTR + RING_RADIUS, CTR + RING_RADIUS, CTR};
    localparam int PATCH_COL [WIN] = '{CTR, CTR - RING_RADIUS, CTR, CTR + RING_RADIUS,
                                       CTR + RING_RADIUS, CTR + RING_RADIUS, CTR,
                                       CTR - RING_RADIUS, CTR - RING_RADIUS};

    // 3x3 bit weights in raster order; the centre carries none.
    localparam logic [7:0] PATCH_WEIGHT [WIN] = '{8'd128, 8'd64, 8'd32, 8'd1, 8'd0,
                                                 8'd16, 8'd2, 8'd4, 8'd8};

    typedef struct packed {
        logic       action;
        logic [7:0] pixel;
    } in_item_t;

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  skip_steps;
        logic [7:0]  threshold;
        logic [9:0]  frame_width;
        logic [12:0] frame_height;
    } cfg_t;

    // One queued item: the nine patch codes (centre first) and the frame end flag.
    typedef struct packed {
        logic [WIN-1:0][7:0] patch;
        logic                last;
    } entry_t;

    typedef struct packed {
        logic clearing;
        logic dividing;
    } front_status_t;

    // 3x3 LBP code of nine samples in raster order.
    function automatic logic [7:0] patch_code(input logic [WIN-1:0][7:0] s);
        logic [7:0] acc;
        acc = 8'd0;
        for (int m = 0; m < WIN; m++) begin
            if (s[m] >= s[CTR]) begin
                acc = acc | PATCH_WEIGHT[m];
            end
        end
        return acc;
    endfunction

endpackage

// ----- hdl/tpc_ram.sv -----
// ---------------------------------------------------------------------------
// tpc_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module tpc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port; a read at the address being written returns old data.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/tpc_front.sv -----
// ---------------------------------------------------------------------------
// tpc_front
// Accepts pixels, keeps the raster counters, the eight-row line store and
// the 9x9 window, and pushes the nine patch codes of every emitting item.
// ---------------------------------------------------------------------------
module tpc_front import tpc_pkg::*; #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  in_item_t                       in_data,
    input  cfg_t                           cfg,
    input  logic                           resync,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
    output logic                           q_push,
    output entry_t                         q_entry,
    output front_status_t                  status
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int NW  = $clog2(MAX_WIDTH + 1);
    localparam int EW  = NW + ROW_W;
    localparam int DCW = $clog2(EW + 1);
    localparam int QSW = $clog2(QUEUE_DEPTH + 3);

    // Effective sizes.
    logic [NW-1:0]    w_eff;
    logic [ROW_W-1:0] h_eff;
    logic [EW-1:0]    wh;

    always_comb
    begin
        if (cfg.frame_width == 10'd0)
        begin
            w_eff = NW'(1);
        end
        else if (32'(cfg.frame_width) > 32'(MAX_WIDTH))
        begin
            w_eff = NW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = NW'(cfg.frame_width);
        end
        if (cfg.frame_height == 13'd0)
        begin
            h_eff = 13'd1;
        end
        else if (32'(cfg.frame_height) > 32'(MAX_HEIGHT))
        begin
            h_eff = ROW_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = cfg.frame_height;
        end
        wh = EW'(w_eff) * EW'(h_eff);
    end

    // Counter registers.
    logic [CW-1:0]    col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [EW-1:0]    em_reg;
    logic [CW-1:0]    pcol_reg;
    logic [EW-1:0]    prow_reg;
    logic             clr_busy_reg;
    logic [CW-1:0]    clr_addr_reg;
    logic             div_busy_reg;
    logic [DCW-1:0]   div_cnt_reg;
    logic [EW-1:0]    div_sh_reg;
    logic [NW-1:0]    div_rem_reg;

    // Pipeline registers.
    logic             f1_valid_reg;
    logic             f1_emit_reg;
    logic             f1_last_reg;
    logic [CW-1:0]    f1_col_reg;
    logic [7:0]       f1_sample_reg;
    logic [WIN-1:0]   f1_rowm_reg;
    logic [WIN-1:0]   f1_colm_reg;
    logic             fwd_hit_reg;
    logic [63:0]      fwd_data_reg;
    logic [WIN-1:0][WIN-1:0][7:0] win_reg;
    logic             f2_valid_reg;
    logic             f2_last_reg;
    logic [WIN-1:0]   f2_rowm_reg;
    logic [WIN-1:0]   f2_colm_reg;

    // Raster position of this item and whether it releases a code.
    logic                accept;
    logic                wrap0;
    logic [CW-1:0]       col0;
    logic [ROW_W-1:0]    row0;
    logic [ROW_W+NW-1:0] n_pos;
    logic [ROW_W+NW-1:0] first_pos;
    logic                emit;
    logic [NW-1:0]       col_inc;
    logic                wrap1;
    logic [CW-1:0]       col1;
    logic [ROW_W-1:0]    row1;
    logic [EW-1:0]       em_inc;
    logic                last;
    logic [NW-1:0]       pcol_inc;
    logic                pwrap;
    logic [WIN-1:0]      rowm;
    logic [WIN-1:0]      colm;
    logic [EW:0]         rsum;
    logic [NW:0]         csum;
    logic [QSW-1:0]      pending;

    always_comb
    begin
        wrap0     = NW'(col_reg) >= w_eff;
        col0      = wrap0 ? '0 : col_reg;
        row0      = wrap0 ? row_reg + 13'd1 : row_reg;
        n_pos     = (ROW_W+NW)'(row0) * (ROW_W+NW)'(w_eff) + (ROW_W+NW)'(col0);
        first_pos = ((ROW_W+NW)'(w_eff) << 2) + (ROW_W+NW)'(4);
        emit      = n_pos >= first_pos;
        col_inc   = NW'(col0) + NW'(1);
        wrap1     = col_inc >= w_eff;
        col1      = wrap1 ? '0 : col_inc[CW-1:0];
        row1      = wrap1 ? row0 + 13'd1 : row0;
        em_inc    = em_reg + EW'(1);
        last      = em_inc >= wh;
        pcol_inc  = NW'(pcol_reg) + NW'(1);
        pwrap     = pcol_inc >= w_eff;
        for (int j = 0; j < WIN; j++)
        begin
            rsum    = (EW+1)'(prow_reg) + (EW+1)'(j);
            rowm[j] = (rsum >= (EW+1)'(CTR)) && (rsum < (EW+1)'(h_eff) + (EW+1)'(CTR));
        end
        for (int k = 0; k < WIN; k++)
        begin
            csum    = (NW+1)'(pcol_reg) + (NW+1)'(k);
            colm[k] = (csum >= (NW+1)'(CTR)) && (csum < (NW+1)'(w_eff) + (NW+1)'(CTR));
        end
        // Credits: queued items plus emitting items still in flight.
        pending   = QSW'(q_count) + QSW'(f1_valid_reg && f1_emit_reg) + QSW'(f2_valid_reg);
        in_ready  = !clr_busy_reg && !div_busy_reg && (pending < QSW'(QUEUE_DEPTH));
        accept    = in_valid && in_ready;
    end

    // Line store: column of eight rows, row j at bits 8j+7:8j.
    logic          ram_we;
    logic [CW-1:0] ram_waddr;
    logic [63:0]   ram_wdata;
    logic [63:0]   ram_rdata;
    logic [63:0]   col_data;

    assign col_data  = fwd_hit_reg ? fwd_data_reg : ram_rdata;
    assign ram_we    = clr_busy_reg || f1_valid_reg;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : f1_col_reg;
    assign ram_wdata = clr_busy_reg ? 64'd0 : {f1_sample_reg, col_data[63:8]};

    tpc_ram #(
        .WIDTH (64),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col0),
        .rdata (ram_rdata)
    );

    // Counters, clearing pass and position divider.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            em_reg       <= '0;
            pcol_reg     <= '0;
            prow_reg     <= '0;
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
            div_sh_reg   <= '0;
            div_rem_reg  <= '0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + CW'(1);
                if (clr_addr_reg == CW'(MAX_WIDTH - 1))
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            if (resync)
            begin
                div_busy_reg <= 1'b1;
                div_cnt_reg  <= DCW'(EW);
                div_sh_reg   <= em_reg;
                div_rem_reg  <= '0;
            end
            else if (div_busy_reg)
            begin
                logic [NW:0] rem_sh;
                logic        ge;
                logic [NW:0] rem_new;
                rem_sh  = {div_rem_reg, div_sh_reg[EW-1]};
                ge      = rem_sh >= (NW+1)'(w_eff);
                rem_new = ge ? rem_sh - (NW+1)'(w_eff) : rem_sh;
                div_rem_reg <= rem_new[NW-1:0];
                div_sh_reg  <= {div_sh_reg[EW-2:0], ge};
                div_cnt_reg <= div_cnt_reg - DCW'(1);
                if (div_cnt_reg == DCW'(1))
                begin
                    div_busy_reg <= 1'b0;
                    pcol_reg     <= rem_new[CW-1:0];
                    prow_reg     <= {div_sh_reg[EW-2:0], ge};
                end
            end
            if (accept)
            begin
                col_reg <= col1;
                row_reg <= row1;
                if (emit)
                begin
                    if (last)
                    begin
                        em_reg   <= '0;
                        col_reg  <= '0;
                        row_reg  <= '0;
                        pcol_reg <= '0;
                        prow_reg <= '0;
                    end
                    else
                    begin
                        em_reg <= em_inc;
                        if (pwrap)
                        begin
                            pcol_reg <= '0;
                            prow_reg <= prow_reg + EW'(1);
                        end
                        else
                        begin
                            pcol_reg <= pcol_inc[CW-1:0];
                        end
                    end
                end
            end
        end
    end

    // Stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            win_reg      <= '0;
        end
        else
        begin
            f1_valid_reg <= accept;
            f2_valid_reg <= f1_valid_reg && f1_emit_reg;
            fwd_hit_reg  <= accept && f1_valid_reg && (col0 == f1_col_reg);
            if (f1_valid_reg)
            begin
                for (int j = 0; j < WIN; j++)
                begin
                    for (int k = 0; k < WIN - 1; k++)
                    begin
                        win_reg[j][k] <= win_reg[j][k+1];
                    end
                end
                for (int j = 0; j < WIN - 1; j++)
                begin
                    win_reg[j][WIN-1] <= col_data[8*j +: 8];
                end
                win_reg[WIN-1][WIN-1] <= f1_sample_reg;
            end
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        f1_emit_reg   <= emit;
        f1_last_reg   <= last;
        f1_col_reg    <= col0;
        f1_sample_reg <= in_data.action ? 8'd0 : in_data.pixel;
        f1_rowm_reg   <= rowm;
        f1_colm_reg   <= colm;
        fwd_data_reg  <= ram_wdata;
        f2_last_reg   <= f1_last_reg;
        f2_rowm_reg   <= f1_rowm_reg;
        f2_colm_reg   <= f1_colm_reg;
    end

    // Mask samples outside the frame and form the nine patch codes.
    always_comb
    begin
        logic [WIN-1:0][WIN-1:0][7:0] pw;
        logic [WIN-1:0][7:0]          s;
        for (int j = 0; j < WIN; j++)
        begin
            for (int k = 0; k < WIN; k++)
            begin
                pw[j][k] = (f2_rowm_reg[j] && f2_colm_reg[k]) ? win_reg[j][k] : 8'd0;
            end
        end
        for (int p = 0; p < WIN; p++)
        begin
            for (int dr = 0; dr < 3; dr++)
            begin
                for (int dc = 0; dc < 3; dc++)
                begin
                    s[3*dr + dc] = pw[PATCH_ROW[p] + dr - 1][PATCH_COL[p] + dc - 1];
                end
            end
            q_entry.patch[p] = patch_code(s);
        end
        q_entry.last = f2_last_reg;
    end

    assign q_push          = f2_valid_reg;
    assign status.clearing = clr_busy_reg;
    assign status.dividing = div_busy_reg;

endmodule

// ----- hdl/tpc_queue.sv -----
// ---------------------------------------------------------------------------
// tpc_queue
// Short register queue of patch-code entries between front and back.
// ---------------------------------------------------------------------------
module tpc_queue import tpc_pkg::*; (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  entry_t                           push_entry,
    input  logic                             pop,
    output entry_t                           head,
    output logic                             not_empty,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int CNW = $clog2(QUEUE_DEPTH + 1);

    entry_t         slot_reg [QUEUE_DEPTH];
    logic [PW-1:0]  wptr_reg;
    logic [PW-1:0]  rptr_reg;
    logic [CNW-1:0] count_reg;

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + PW'(1);
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + PW'(1);
            end
            count_reg <= count_reg + CNW'(push) - CNW'(pop);
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_entry;
        end
    end

    assign head      = slot_reg[rptr_reg];
    assign not_empty = count_reg != '0;
    assign count     = count_reg;

endmodule

// ----- hdl/tpc_back.sv -----
// ---------------------------------------------------------------------------
// tpc_back
// Compares ring patch codes against the centre code and delivers the
// three-patch code through an elastic two-stage pipeline.
// ---------------------------------------------------------------------------
module tpc_back import tpc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_valid,
    output logic      q_pop,
    input  entry_t    q_head,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    logic                b1_valid_reg;
    logic [7:0][7:0]     b1_diff_reg;
    logic                b1_last_reg;
    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic out_load;
    logic b1_free;

    assign out_load = b1_valid_reg && (!out_valid_reg || out_ready);
    assign b1_free  = !b1_valid_reg || out_load;
    assign q_pop    = q_valid && b1_free;

    // Absolute distance of each ring patch code from the centre code.
    logic [7:0][7:0] diff;
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            diff[i] = (q_head.patch[i+1] >= q_head.patch[0]) ?
                      q_head.patch[i+1] - q_head.patch[0] :
                      q_head.patch[0] - q_head.patch[i+1];
        end
    end

    // Ring point i sets bit 7-i when its distance exceeds that of point i+skip_steps
    logic [7:0] code;
    always_comb
    begin
        logic [2:0] sel;
        for (int i = 0; i < 8; i++)
        begin
            sel         = 3'(i) + cfg.skip_steps;
            code[7 - i] = 9'(b1_diff_reg[i]) > 9'(b1_diff_reg[sel]) + 9'(cfg.threshold);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (b1_free)
            begin
                b1_valid_reg <= q_valid;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            b1_diff_reg <= diff;
            b1_last_reg <= q_head.last;
        end
        if (out_load)
        begin
            out_data_reg.code <= code;
            out_data_reg.last <= b1_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- hdl/three_patch_lbp_texture_code.sv -----
// ---------------------------------------------------------------------------
// three_patch_lbp_texture_code
// Streaming three-patch texture coder: one 8-bit code per raster pixel.
//
//   channel  signals                          beat
//   in       in_valid / in_ready / in_data    action, pixel
//   out      out_valid / out_ready / out_data code, last
//   cfg      cfg_we / cfg_index / cfg_data    register write, no wait
//
// One beat is accepted per clock while in_ready is high. A code leaves after
// the beat that releases it passes the line store read, window shift, patch
// codes, queue and two compare stages. After reset a clearing pass over all
// MAX_WIDTH addresses zeroes the line store with in_ready low. A frame_width
// write starts a bit-serial position divider with in_ready low. The output
// register and four-entry queue let the input flow on while out_ready is low,
// until the queue credits run out and in_ready drops.
module three_patch_lbp_texture_code import tpc_pkg::*; #(
    parameter int MAX_WIDTH = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    // Configuration registers.
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.skip_steps   <= RST_SKIP;
            cfg_reg.threshold    <= RST_THRESHOLD;
            cfg_reg.frame_width  <= RST_WIDTH;
            cfg_reg.frame_height <= RST_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SKIP:      cfg_reg.skip_steps   <= cfg_data[2:0];
                CFG_THRESHOLD: cfg_reg.threshold    <= cfg_data[7:0];
                CFG_WIDTH:     cfg_reg.frame_width  <= cfg_data[9:0];
                CFG_HEIGHT:    cfg_reg.frame_height <= cfg_data;
                default:       cfg_reg.skip_steps   <= cfg_reg.skip_steps;
            endcase
        end
    end

    logic resync;
    assign resync = cfg_we && (cfg_index == CFG_WIDTH);

    logic           q_push;
    entry_t         q_entry;
    logic           q_pop;
    entry_t         q_head;
    logic           q_not_empty;
    logic [QCW-1:0] q_count;
    front_status_t  front_status;

    tpc_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .cfg      (cfg_reg),
        .resync   (resync),
        .q_count  (q_count),
        .q_push   (q_push),
        .q_entry  (q_entry),
        .status   (front_status)
    );

    tpc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .not_empty  (q_not_empty),
        .count      (q_count)
    );

    tpc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_not_empty),
        .q_pop     (q_pop),
        .q_head    (q_head),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

`ifndef ASSERT_OFF
    // The credit check must keep the queue from overflowing.
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (q_count < QCW'(QUEUE_DEPTH)) || q_pop)
        else $error("queue push while full");

    // The back end never pops an empty queue.
    a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("queue pop while empty");

    // No beat is taken during the clearing pass or the position divider.
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (front_status.clearing || front_status.dividing) |-> !in_ready)
        else $error("input ready while front is busy");
`endif

endmodule

// ----- verif/three_patch_lbp_texture_code_tb.sv -----
// ---------------------------------------------------------------------------
// Testbench for the three-patch texture coder
// Streams pixel and drain beats into the coder and predicts every code in a
// behavioral model of the padded 9x9 window, then compares each output beat
// with the oldest predicted code. Both sides idle at random.
// ---------------------------------------------------------------------------
module three_patch_lbp_texture_code_tb;
    import tpc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAXW = 512;
    localparam int ACT_PIXEL = 0;
    localparam int ACT_DRAIN = 1;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [12:0] cfg_data;

    three_patch_lbp_texture_code #(.MAX_WIDTH(MAXW)) uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Predictor state.
    logic [2:0]  m_skip;
    logic [7:0]  m_thresh;
    logic [9:0]  m_width;
    logic [12:0] m_height;
    logic [7:0]  m_lines [8][MAXW];
    logic [7:0]  m_win [9][9];
    int unsigned m_col;
    int unsigned m_row;
    int unsigned m_emitted;

    out_item_t   code_queue [$];
    int          errors;
    int          in_idle_pct;
    int          out_idle_pct;
    bit          hold_out;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Some tests failed");
        $finish;
    end

    function automatic int eff_w();
        if (m_width == 0) return 1;
        if (m_width > MAXW) return MAXW;
        return m_width;
    endfunction

    function automatic int eff_h();
        if (m_height == 0) return 1;
        if (m_height > MAX_HEIGHT) return MAX_HEIGHT;
        return m_height;
    endfunction

    // LBP code of the 3x3 patch centred at (r, c) in a masked window.
    function automatic int lbp3(ref logic [7:0] pw [9][9], input int r, input int c);
        int acc;
        int wts [9];
        int m;
        wts = '{128, 64, 32, 1, 0, 16, 2, 4, 8};
        acc = 0;
        m = 0;
        for (int dr = -1; dr <= 1; dr++)
        begin
            for (int dc = -1; dc <= 1; dc++)
            begin
                if (pw[r + dr][c + dc] >= pw[r][c]) acc += wts[m];
                m++;
            end
        end
        return acc;
    endfunction

    // Advance the predictor by one accepted beat; queue a code if one is due.
    task automatic predict_code(input in_item_t it);
        int w;
        int h;
        int n;
        int col;
        int prow;
        int pcol;
        int rr;
        int cc;
        int lc;
        int a1;
        int a2;
        int ring [8];
        int rdr [8];
        int rdc [8];
        logic [7:0] smp;
        logic [7:0] ncol [9];
        logic [7:0] pw [9][9];
        out_item_t o;
        rdr = '{-3, -3, -3, 0, 3, 3, 3, 0};
        rdc = '{-3, 0, 3, 3, 3, 0, -3, -3};
        w = eff_w();
        h = eff_h();
        smp = (it.action == ACT_DRAIN) ? 8'd0 : it.pixel;
        if (m_col >= w)
        begin
            m_col = 0;
            m_row = (m_row + 1) & 13'h1fff;
        end
        col = m_col;
        n = m_row * w + col;
        for (int j = 0; j < 8; j++) ncol[j] = m_lines[j][col];
        ncol[8] = smp;
        for (int j = 0; j < 7; j++) m_lines[j][col] = m_lines[j + 1][col];
        m_lines[7][col] = smp;
        for (int j = 0; j < 9; j++)
        begin
            for (int k = 0; k < 8; k++) m_win[j][k] = m_win[j][k + 1];
            m_win[j][8] = ncol[j];
        end
        m_col++;
        if (m_col >= w)
        begin
            m_col = 0;
            m_row = (m_row + 1) & 13'h1fff;
        end
        if (n < 4 * w + 4) return;
        prow = m_emitted / w;
        pcol = m_emitted % w;
        for (int j = 0; j < 9; j++)
        begin
            for (int k = 0; k < 9; k++)
            begin
                rr = prow - 4 + j;
                cc = pcol - 4 + k;
                pw[j][k] = (rr >= 0 && rr < h && cc >= 0 && cc < w) ? m_win[j][k] : 8'd0;
            end
        end
        lc = lbp3(pw, 4, 4);
        for (int i = 0; i < 8; i++) ring[i] = lbp3(pw, 4 + rdr[i], 4 + rdc[i]);
        o.code = '0;
        for (int i = 0; i < 8; i++)
        begin
            a1 = ring[i] - lc;
            a2 = ring[(i + m_skip) & 7] - lc;
            if (a1 < 0) a1 = -a1;
            if (a2 < 0) a2 = -a2;
            if (a1 - a2 > int'(m_thresh)) o.code[7 - i] = 1'b1;
        end
        o.last = 1'b0;
        m_emitted++;
        if (m_emitted >= w * h)
        begin
            o.last = 1'b1;
            m_emitted = 0;
            m_col = 0;
            m_row = 0;
        end
        code_queue.push_back(o);
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Send one beat and run it through the predictor when accepted.
    // Valid stays high after the beat; idle cycles or wait_idle lower it.
    task automatic send_beat(input bit act, input logic [7:0] px);
        in_item_t it;
        it.action = act;
        it.pixel = px;
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        do @(posedge clk); while (!in_ready);
        predict_code(it);
    endtask

    // Wait for all codes, then let the pipeline settle before a register write.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (code_queue.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [12:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_SKIP:      m_skip = val[2:0];
            CFG_THRESHOLD: m_thresh = val[7:0];
            CFG_WIDTH:     m_width = val[9:0];
            default:       m_height = val;
        endcase
    endtask

    // Feed a configured frame whole, then drain it out.
    task automatic run_frame(input int w, input int h, input int mode);
        for (int i = 0; i < w * h; i++)
        begin
            case (mode)
                0: send_beat(ACT_PIXEL, 8'($urandom_range(255)));
                1: send_beat(ACT_PIXEL, (i % 2) ? 8'hff : 8'h00);
                default: send_beat(ACT_PIXEL, 8'($urandom_range(3) * 85));
            endcase
        end
        for (int i = 0; i < 4 * w + 4; i++) send_beat(ACT_DRAIN, 8'($urandom_range(255)));
    endtask

    task automatic set_frame(input int sk, input int th, input int w, input int h);
        wait_idle();
        write_reg(CFG_SKIP, 13'(sk));
        write_reg(CFG_THRESHOLD, 13'(th));
        write_reg(CFG_WIDTH, 13'(w));
        write_reg(CFG_HEIGHT, 13'(h));
        cfg_we <= 1'b0;
    endtask

    // Directed: extremes of sizes, skip and threshold, odd inputs.
    task automatic test_directed();
        set_frame(0, 0, 1, 1);
        send_beat(ACT_PIXEL, 8'hff);
        send_beat(ACT_PIXEL, 8'h00);
        send_beat(ACT_DRAIN, 8'h5a);
        send_beat(ACT_PIXEL, 8'h80);
        send_beat(ACT_DRAIN, 8'ha5);
        set_frame(1, 255, 3, 2);
        run_frame(3, 2, 1);
        set_frame(7, 0, 4, 3);
        run_frame(4, 3, 2);
    endtask

    // Out-of-range sizes are clamped by the block.
    task automatic test_clamped_sizes();
        set_frame(3, 10, 0, 0);
        run_frame(1, 1, 0);
        set_frame(2, 5, 1023, 1);
        run_frame(2, 1, 0);
        set_frame(5, 1, 9, 8191);
        for (int i = 0; i < 60; i++) send_beat(ACT_PIXEL, 8'($urandom_range(255)));
    endtask

    // Random frames with random settings and some stray pixel or drain beats.
    task automatic test_random_frames();
        int w;
        int h;
        int sent;
        sent = 0;
        while (sent < 1500)
        begin
            w = $urandom_range(1, 14);
            h = $urandom_range(1, 8);
            set_frame($urandom_range(7), $urandom_range(3) == 0 ? $urandom_range(255) :
                      $urandom_range(30), w, h);
            in_idle_pct = ($urandom_range(3) == 0) ? 0 : 30;
            out_idle_pct = ($urandom_range(3) == 0) ? 0 : 30;
            run_frame(w, h, $urandom_range(2));
            if ($urandom_range(4) == 0)
                send_beat($urandom_range(1), 8'($urandom_range(255)));
            sent += w * h + 4 * w + 4;
        end
        in_idle_pct = 30;
        out_idle_pct = 30;
    endtask

    // Output held off while input keeps coming, to fill the pipeline.
    task automatic test_backpressure();
        set_frame(1, 20, 6, 4);
        hold_out = 1'b1;
        run_frame(6, 4, 0);
        wait_idle();
    endtask

    // Output sink with random stalls and a long hold on request.
    initial
    begin
        int hold;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_out)
            begin
                hold_out = 1'b0;
                out_ready <= 1'b0;
                for (hold = 0; hold < 300; hold++) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // Compare each accepted code with the oldest prediction.
    initial
    begin
        out_item_t exp_item;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (code_queue.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected code %h", out_data.code));
                end
                else
                begin
                    exp_item = code_queue.pop_front();
                    if (out_data.code !== exp_item.code)
                        report_mismatch($sformatf("code %h, expected %h",
                                                  out_data.code, exp_item.code));
                    if (out_data.last !== exp_item.last)
                        report_mismatch($sformatf("last %b, expected %b",
                                                  out_data.last, exp_item.last));
                end
            end
        end
    end

    initial
    begin
        errors = 0;
        in_idle_pct = 30;
        out_idle_pct = 30;
        hold_out = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_SKIP;
        cfg_data = '0;
        m_skip = RST_SKIP;
        m_thresh = RST_THRESHOLD;
        m_width = RST_WIDTH;
        m_height = RST_HEIGHT;
        m_col = 0;
        m_row = 0;
        m_emitted = 0;
        for (int j = 0; j < 8; j++)
            for (int k = 0; k < MAXW; k++) m_lines[j][k] = 8'd0;
        for (int j = 0; j < 9; j++)
            for (int k = 0; k < 9; k++) m_win[j][k] = 8'd0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_clamped_sizes();
        test_backpressure();
        test_random_frames();
        wait_idle();
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/tpc_pkg.sv
hdl/tpc_ram.sv
hdl/tpc_front.sv
hdl/tpc_queue.sv
hdl/tpc_back.sv
hdl/three_patch_lbp_texture_code.sv
verif/three_patch_lbp_texture_code_tb.sv
